// ----- hdl/led_fade_ramp_controller_assert.svh -----
// ---------------------------------------------------------------------------
// led fade ramp controller assertion macros
// clocked property checks that compile away in synthesis
// ---------------------------------------------------------------------------
`ifndef LED_FADE_RAMP_CONTROLLER_ASSERT_SVH
`define LED_FADE_RAMP_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// check on every clock edge outside reset
`define LFR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("led fade ramp controller check failed");

// check on every clock edge, reset included
`define LFR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("led fade ramp controller check failed");

`else

`define LFR_ASSERT(label, prop)
`define LFR_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- hdl/lfr_pkg.sv -----
// ---------------------------------------------------------------------------
// lfr_pkg
// types and constants shared by the led fade ramp controller
// ---------------------------------------------------------------------------
package lfr_pkg;

  localparam int DUTY_W = 8;
  localparam int DUR_W  = 32;
  localparam int MODE_W = 3;
  localparam int CNT_W  = $clog2(DUR_W);

  localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;
  localparam logic [DUTY_W-1:0] DUTY_OFF  = 8'd0;
  localparam logic [DUR_W-1:0]  ELAPSED_MAX = '1;

  // command codes
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OFF    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SET    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FADE   = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DUTY_W-1:0] duty_value;
    logic [DUR_W-1:0]  duration_ms;
  } lfr_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_out;
    logic              fading;
  } lfr_out_t;

endpackage

// ----- hdl/led_fade_ramp_controller.sv -----
// ---------------------------------------------------------------------------
// led_fade_ramp_controller
// 8-bit led duty controller with timed fades driven by millisecond ticks
// ---------------------------------------------------------------------------
// Usage: each item on the in_ channel is one command (tick, on, off, toggle,
// set duty, fade to target). Every item yields exactly one item on the out_
// channel carrying the duty after the command and a fading flag.
// Output: the result is registered and shows on out_valid in the cycle after
// the item is accepted, for every command.
// Busy: tick, on, off, toggle, set, ignored fades and fades onto the current
// duty leave the block ready for the next item. Any other fade runs the step
// interval through a shared radix-2 restoring divider, one quotient bit per
// cycle, and in_ready stays low until the divider has finished.
// Reset (rst_n low, synchronous): duty, target, step interval and elapsed
// count go to zero, the divider stops and the out register empties.
// Stall: the out register holds one finished item; while it is full and
// out_ready is low, in_ready is low and no new item is taken. A result that
// is being taken frees the slot in the same cycle.
// ---------------------------------------------------------------------------
`include "led_fade_ramp_controller_assert.svh"

module led_fade_ramp_controller
  import lfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lfr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lfr_out_t out_data
);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DUR_W - 1);

  state_t             state_r,    state_nxt;
  logic [DUTY_W-1:0]  cur_r,      cur_nxt;
  logic [DUTY_W-1:0]  tgt_r,      tgt_nxt;
  logic [DUR_W-1:0]   interval_r, interval_nxt;
  logic [DUR_W-1:0]   elapsed_r,  elapsed_nxt;
  logic [DUR_W-1:0]   quo_r,      quo_nxt;
  logic [DUTY_W-1:0]  rem_r,      rem_nxt;
  logic [DUTY_W-1:0]  divisor_r,  divisor_nxt;
  logic [CNT_W-1:0]   cnt_r,      cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  lfr_out_t           out_data_r,  out_data_nxt;

  logic               accept;
  logic [DUR_W-1:0]   elapsed_inc;
  logic [DUTY_W-1:0]  span;
  logic [DUTY_W:0]    trial;
  logic [DUTY_W:0]    trial_diff;
  logic               quo_bit;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign span = (cur_r < in_data.duty_value) ? in_data.duty_value - cur_r
                                             : cur_r - in_data.duty_value;

  // shared divider step: bring down the next dividend bit, trial subtract
  assign trial      = {rem_r, quo_r[DUR_W-1]};
  assign trial_diff = trial - {1'b0, divisor_r};
  assign quo_bit    = (trial >= {1'b0, divisor_r});

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    tgt_nxt       = tgt_r;
    interval_nxt  = interval_r;
    elapsed_nxt   = elapsed_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    divisor_nxt   = divisor_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.mode)
            MODE_TICK: begin
              if (cur_r != tgt_r) begin
                if (elapsed_inc >= interval_r) begin
                  cur_nxt     = (cur_r < tgt_r) ? cur_r + 1'b1 : cur_r - 1'b1;
                  elapsed_nxt = '0;
                end else begin
                  elapsed_nxt = elapsed_inc;
                end
              end
            end
            MODE_ON: begin
              cur_nxt = DUTY_FULL;
              tgt_nxt = DUTY_FULL;
            end
            MODE_OFF: begin
              cur_nxt = DUTY_OFF;
              tgt_nxt = DUTY_OFF;
            end
            MODE_TOGGLE: begin
              cur_nxt = (cur_r != DUTY_OFF) ? DUTY_OFF : DUTY_FULL;
              tgt_nxt = cur_nxt;
            end
            MODE_SET: begin
              cur_nxt = in_data.duty_value;
              tgt_nxt = in_data.duty_value;
            end
            MODE_FADE: begin
              if (in_data.duty_value != tgt_r) begin
                tgt_nxt     = in_data.duty_value;
                elapsed_nxt = '0;
                if (span == '0) begin
                  interval_nxt = '0;
                end else begin
                  quo_nxt     = in_data.duration_ms;
                  rem_nxt     = '0;
                  divisor_nxt = span;
                  cnt_nxt     = '0;
                  state_nxt   = ST_DIV;
                end
              end
            end
            default: begin
            end
          endcase
          // result does not depend on the interval, so it leaves right away
          out_valid_nxt         = 1'b1;
          out_data_nxt.duty_out = cur_nxt;
          out_data_nxt.fading   = (cur_nxt != tgt_nxt);
        end
      end
      ST_DIV: begin
        rem_nxt = quo_bit ? trial_diff[DUTY_W-1:0] : trial[DUTY_W-1:0];
        quo_nxt = {quo_r[DUR_W-2:0], quo_bit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          interval_nxt = quo_nxt;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      tgt_r       <= '0;
      interval_r  <= '0;
      elapsed_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      tgt_r       <= tgt_nxt;
      interval_r  <= interval_nxt;
      elapsed_r   <= elapsed_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    divisor_r  <= divisor_nxt;
    out_data_r <= out_data_nxt;
  end

  // divider runs its full length once started
  `LFR_ASSERT(a_div_runs, (state_r == ST_DIV && cnt_r != DIV_LAST) |=> (state_r == ST_DIV))
  // partial remainder always stays below the divisor
  `LFR_ASSERT(a_rem_bound, (state_r == ST_DIV) |-> (rem_r < divisor_r))
  // every accepted item puts a result in the out register
  `LFR_ASSERT(a_item_result, (in_valid && in_ready) |=> out_valid)
  // a tick with no fade in progress leaves the duty alone
  `LFR_ASSERT(a_idle_tick, (accept && in_data.mode == MODE_TICK && cur_r == tgt_r) |=> $stable(cur_r))
  // duty never moves while the divider works
  `LFR_ASSERT_ALWAYS(a_div_hold, (rst_n && state_r == ST_DIV) |=> (!rst_n || $stable(cur_r)))

endmodule
